FILE: rtl/dram_open_page_command_scheduler_top_assert.svh
// Assertion macros shared by the scheduler checker
`ifndef DRAM_OPEN_PAGE_COMMAND_SCHEDULER_TOP_ASSERT_SVH
`define DRAM_OPEN_PAGE_COMMAND_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define DOPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DOPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/dops_pkg.sv
// Package: constants, types and helpers of the DRAM command scheduler
`timescale 1ns / 1ps
`default_nettype none
package dops_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int BANK_COUNT  = 16;
    localparam int ROW_BITS    = 16;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int BANK_W  = $clog2(BANK_COUNT);
    localparam int ROW_W   = (ROW_BITS < 16) ? ROW_BITS : 16;
    localparam int ENTRY_W = 35;
    localparam int NUM_REGS = 8;

    // Command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_PRE   = 3'd1;
    localparam logic [2:0] CMD_ACT   = 3'd2;
    localparam logic [2:0] CMD_RD    = 3'd3;
    localparam logic [2:0] CMD_WR    = 3'd4;

    // Request kinds
    localparam logic [1:0] KIND_WRITE = 2'd1;

    // Configuration register indexes
    localparam logic [2:0] REG_ACT_CMD   = 3'd0;
    localparam logic [2:0] REG_ACT_PRE   = 3'd1;
    localparam logic [2:0] REG_PRE_DUR   = 3'd2;
    localparam logic [2:0] REG_RD_PRE    = 3'd3;
    localparam logic [2:0] REG_GAP_SAME  = 3'd4;
    localparam logic [2:0] REG_GAP_OTHER = 3'd5;
    localparam logic [2:0] REG_WR_REC    = 3'd6;
    localparam logic [2:0] REG_PAGE_LIM  = 3'd7;

    localparam logic [7:0] REG_RESET [NUM_REGS] = '{8'd24, 8'd52, 8'd24, 8'd12,
                                                    8'd8, 8'd4, 8'd20, 8'd150};

    // Shared timer indexes
    localparam logic [2:0] T_CCD_L = 3'd0;
    localparam logic [2:0] T_CCD_S = 3'd1;
    localparam logic [2:0] T_RTP   = 3'd2;
    localparam logic [2:0] T_WR    = 3'd3;
    localparam logic [2:0] T_RCD   = 3'd4;
    localparam logic [2:0] T_RAS   = 3'd5;
    localparam logic [2:0] T_WTR_L = 3'd6;
    localparam logic [2:0] T_WTR_S = 3'd7;

    localparam logic [7:0] WTR_GAP_LONG  = 8'd16;
    localparam logic [7:0] WTR_GAP_SHORT = 8'd8;

    // Queue status toward the scheduling logic
    typedef struct packed {
        logic               accepted;
        logic               head_valid;
        logic [ENTRY_W-1:0] head;
        logic [CNT_W-1:0]   count_after;
    } q_status_t;

    // One result per tick
    typedef struct packed {
        logic        accepted;
        logic [2:0]  command;
        logic [1:0]  group;
        logic [1:0]  bank;
        logic [15:0] row_or_column;
        logic [4:0]  queue_count;
    } result_t;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Fold group/bank into the bank array range
    function automatic logic [BANK_W-1:0] bank_index(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        for (int k = 0; k < 4; k++)
        begin
            if (r >= 4'(BANK_COUNT))
                r = r - 4'(BANK_COUNT);
        end
        return r[BANK_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dops_req_queue.sv
// In-order request queue on a synchronous memory with a prefetched head
`timescale 1ns / 1ps
`default_nettype none
module dops_req_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  logic                          enq_req,
    input  logic [dops_pkg::ENTRY_W-1:0]  enq_data,
    input  logic                          deq,
    output dops_pkg::q_status_t           status
);
    import dops_pkg::*;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               fwd_reg;
    logic               enq;
    logic               do_deq;
    logic [CNT_W-1:0]   count_after;
    logic [ENTRY_W-1:0] head_sel;

    // Take the request if there is room
    assign enq         = tick && enq_req && (count_reg < CNT_W'(QUEUE_DEPTH));
    assign do_deq      = tick && deq;
    assign count_after = count_reg + CNT_W'(enq);

    assign wr_ptr_next = enq ? ptr_next(wr_ptr_reg) : wr_ptr_reg;
    assign rd_ptr_next = do_deq ? ptr_next(rd_ptr_reg) : rd_ptr_reg;
    assign count_next  = tick ? (count_after - CNT_W'(do_deq)) : count_reg;

    // Head: bypass the incoming request when the queue is empty
    assign head_sel = (count_reg == '0) ? enq_data
                    : (fwd_reg ? fwd_data_reg : rd_data_reg);
    assign status   = '{accepted: enq, head_valid: (count_after != '0),
                        head: head_sel, count_after: count_after};

    // Write the store, read the next head into a register ahead of use
    always_ff @(posedge clk)
    begin
        if (enq)
            mem[wr_ptr_reg] <= enq_data;
        rd_data_reg  <= mem[rd_ptr_next];
        fwd_data_reg <= enq_data;
    end

    // Advance pointers and forward a write that lands on the next head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            fwd_reg    <= enq && (wr_ptr_reg == rd_ptr_next);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dops_sched_core.sv
// Bank state, timing counters and command decision for the queue head
`timescale 1ns / 1ps
`default_nettype none
module dops_sched_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  dops_pkg::q_status_t  status,
    output logic                 deq,
    output dops_pkg::result_t    result
);
    import dops_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PRE  = 2'd1;
    localparam logic [1:0] PH_ACT  = 2'd2;

    logic [7:0]       cfg_reg   [NUM_REGS];
    logic             valid_reg [BANK_COUNT];
    logic             valid_next[BANK_COUNT];
    logic [ROW_W-1:0] row_reg   [BANK_COUNT];
    logic [ROW_W-1:0] row_next  [BANK_COUNT];
    logic [7:0]       age_reg   [BANK_COUNT];
    logic [7:0]       age_next  [BANK_COUNT];
    logic [7:0]       pt_reg    [BANK_COUNT];
    logic [7:0]       pt_next   [BANK_COUNT];
    logic [7:0]       st_reg    [8];
    logic [7:0]       st_next   [8];
    logic [1:0]       phase_reg, phase_next;
    logic             lg_valid_reg, lg_valid_next;
    logic [1:0]       lg_reg, lg_next;

    logic [32:0]       addr;
    logic              is_write;
    logic [15:0]       row_full;
    logic [ROW_W-1:0]  row;
    logic [1:0]        bnk;
    logic [1:0]        grp;
    logic [9:0]        column;
    logic [BANK_W-1:0] bi;
    logic              hit;
    logic              same;
    logic [7:0]        ccd;
    logic [7:0]        wtr;
    logic              issued;
    logic [CNT_W-1:0]  cnt_left;

    // Slice the head address
    assign addr     = status.head[32:0];
    assign is_write = (status.head[34:33] == KIND_WRITE);
    assign row_full = addr[32:17];
    assign row      = row_full[ROW_W-1:0];
    assign bnk      = addr[16:15];
    assign grp      = addr[7:6];
    assign column   = {addr[14:8], addr[5:3]};
    assign bi       = bank_index({grp, bnk});

    // Count timers, then decide one command
    always_comb
    begin
        for (int i = 0; i < BANK_COUNT; i++)
        begin
            valid_next[i] = valid_reg[i];
            row_next[i]   = row_reg[i];
            age_next[i]   = (age_reg[i] != 8'hFF) ? age_reg[i] + 8'd1 : age_reg[i];
            pt_next[i]    = (pt_reg[i] != 8'd0) ? pt_reg[i] - 8'd1 : 8'd0;
        end
        for (int k = 0; k < 8; k++)
            st_next[k] = (st_reg[k] != 8'd0) ? st_reg[k] - 8'd1 : 8'd0;

        phase_next    = phase_reg;
        lg_valid_next = lg_valid_reg;
        lg_next       = lg_reg;
        deq           = 1'b0;
        issued        = 1'b0;
        result.command       = CMD_NONE;
        result.group         = 2'd0;
        result.bank          = 2'd0;
        result.row_or_column = 16'd0;

        hit  = valid_reg[bi] && (row_reg[bi] == row) && (age_next[bi] <= cfg_reg[REG_PAGE_LIM]);
        same = lg_valid_reg && (lg_reg == grp);
        ccd  = same ? st_next[T_CCD_L] : st_next[T_CCD_S];
        wtr  = same ? st_next[T_WTR_L] : st_next[T_WTR_S];

        if (status.head_valid)
        begin
            if ((phase_reg == PH_IDLE) && !hit)
            begin
                // Miss: precharge first
                if (st_next[T_RTP] == 8'd0 && st_next[T_WR] == 8'd0 &&
                    st_next[T_RAS] == 8'd0 && pt_next[bi] == 8'd0)
                begin
                    phase_next     = PH_PRE;
                    pt_next[bi]    = cfg_reg[REG_PRE_DUR];
                    valid_next[bi] = 1'b0;
                    result.command = CMD_PRE;
                    result.group   = grp;
                    result.bank    = bnk;
                end
            end
            else if (phase_reg == PH_PRE)
            begin
                // Open the row once the bank has precharged
                if (pt_next[bi] == 8'd0)
                begin
                    valid_next[bi]       = 1'b1;
                    row_next[bi]         = row;
                    age_next[bi]         = 8'd0;
                    phase_next           = PH_ACT;
                    st_next[T_RAS]       = cfg_reg[REG_ACT_PRE];
                    st_next[T_RCD]       = cfg_reg[REG_ACT_CMD];
                    result.command       = CMD_ACT;
                    result.group         = grp;
                    result.bank          = bnk;
                    result.row_or_column = 16'(row);
                end
            end
            else
            begin
                // Page hit or row open: column command
                phase_next = PH_ACT;
                if (ccd == 8'd0 && st_next[T_RCD] == 8'd0)
                begin
                    if (is_write)
                    begin
                        st_next[T_WR]    = cfg_reg[REG_WR_REC];
                        st_next[T_WTR_L] = WTR_GAP_LONG;
                        st_next[T_WTR_S] = WTR_GAP_SHORT;
                        result.command   = CMD_WR;
                        issued           = 1'b1;
                    end
                    else if (wtr == 8'd0)
                    begin
                        st_next[T_RTP] = cfg_reg[REG_RD_PRE];
                        result.command = CMD_RD;
                        issued         = 1'b1;
                    end
                    if (issued)
                    begin
                        result.group         = grp;
                        result.bank          = bnk;
                        result.row_or_column = 16'(column);
                        lg_valid_next        = 1'b1;
                        lg_next              = grp;
                        st_next[T_CCD_L]     = cfg_reg[REG_GAP_SAME];
                        st_next[T_CCD_S]     = cfg_reg[REG_GAP_OTHER];
                        phase_next           = PH_IDLE;
                        deq                  = 1'b1;
                    end
                end
            end
        end

        cnt_left           = status.count_after - CNT_W'(deq);
        result.accepted    = status.accepted;
        result.queue_count = 5'(cnt_left);
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
                cfg_reg[r] <= REG_RESET[r];
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Open rows carry no reset; their valid bits do
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            for (int i = 0; i < BANK_COUNT; i++)
                row_reg[i] <= row_next[i];
        end
    end

    // Advance bank and timer state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BANK_COUNT; i++)
            begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= 8'hFF;
                pt_reg[i]    <= 8'd0;
            end
            for (int k = 0; k < 8; k++)
                st_reg[k] <= 8'd0;
            phase_reg    <= PH_IDLE;
            lg_valid_reg <= 1'b0;
            lg_reg       <= 2'd0;
        end
        else if (tick)
        begin
            for (int i = 0; i < BANK_COUNT; i++)
            begin
                valid_reg[i] <= valid_next[i];
                age_reg[i]   <= age_next[i];
                pt_reg[i]    <= pt_next[i];
            end
            for (int k = 0; k < 8; k++)
                st_reg[k] <= st_next[k];
            phase_reg    <= phase_next;
            lg_valid_reg <= lg_valid_next;
            lg_reg       <= lg_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dram_open_page_command_scheduler_top.sv
// Top level of the in-order open-page DRAM command scheduler
//
// Each request on the s_ channel is one DRAM clock tick, optionally carrying
// a new read, write or fetch request that is queued in order (up to
// QUEUE_DEPTH). For every accepted request exactly one result leaves on the
// m_ channel: whether the new request was queued, the command issued this
// tick (none, PRE, ACT, RD, WR) with its target, and the queue fill.
// The result is registered: it sits in the output register the cycle
// after the request is taken. Throughput is one request per cycle while
// m_tready does not stall the output; the head entry is prefetched from the
// queue memory ahead of use, with a bypass when it is written in the same cycle.
// A stall on m_tready holds the output register and drops s_tready, so no
// result is lost; s_tready returns as soon as the result is taken.
// Reset clears the queue, all timers, open-row valid bits and the registers
// to their defaults; no memory sweep is needed. Configuration writes on
// cfg_we take effect at once and belong to idle periods only.
`timescale 1ns / 1ps
`default_nettype none
module dram_open_page_command_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode[0], req_kind[2:1], req_address[35:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // accepted[0], command[3:1], cmd_bank_group[5:4],
                                   // cmd_bank[7:6], row_or_column[23:8], queue_count[28:24]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import dops_pkg::*;

    logic        tick;
    logic        deq;
    q_status_t   status;
    result_t     result;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign tick     = s_tvalid && s_tready;

    dops_req_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .enq_req  (s_tdata[0]),
        .enq_data ({s_tdata[2:1], s_tdata[35:3]}),
        .deq      (deq),
        .status   (status)
    );

    dops_sched_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .deq       (deq),
        .result    (result)
    );

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (tick)
            m_tdata_reg <= {3'b000, result.queue_count, result.row_or_column,
                            result.bank, result.group, result.command, result.accepted};
    end

    // Hold valid until the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (tick)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

FILE: rtl/dops_checker.sv
// Port-level checker for the scheduler top level, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "dram_open_page_command_scheduler_top_assert.svh"
module dops_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);
    import dops_pkg::*;

    // Every taken request yields a result next cycle
    `DOPS_ASSERT_NEXT(a_result_follows, clk, rst_n, s_tvalid && s_tready, m_tvalid)
    // A stalled result blocks new requests
    `DOPS_ASSERT_IMPLY(a_stall_blocks, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    // No command means empty target fields
    `DOPS_ASSERT_IMPLY(a_none_clean, clk, rst_n, m_tvalid && (m_tdata[3:1] == CMD_NONE), m_tdata[23:4] == 20'd0)
    // Codes and fill stay in range
    `DOPS_ASSERT_IMPLY(a_fields_legal, clk, rst_n, m_tvalid, (m_tdata[3:1] <= CMD_WR) && (m_tdata[28:24] <= 5'd16))
    // Precharge carries no row
    `DOPS_ASSERT_IMPLY(a_pre_no_row, clk, rst_n, m_tvalid && (m_tdata[3:1] == CMD_PRE), m_tdata[23:8] == 16'd0)

endmodule

bind dram_open_page_command_scheduler_top dops_checker u_dops_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
